/* rtl/core/hsv_to_rgb_converter_unit_defines.svh */
// Assertion macros shared by the checker of the HSV to RGB converter.
// No dependencies; include by bare file name.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Property checked at every clock edge, reset included.
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Property checked only while reset is released.
`define HSV2RGB_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* rtl/core/hsv2rgb_pkg.sv */
// Package for the HSV to RGB converter: widths, constants, sector codes and
// the stage-enable struct. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int HUE_W   = 16;   // Q0.16 hue
    localparam int SV_W    = 9;    // saturation / brightness, 256 is 1.0
    localparam int CH_W    = 8;    // output channel
    localparam int SHIFT_W = 3;    // brightness shift register
    localparam int SEC_W   = 3;    // hue sector
    localparam int MUL_W   = 25;   // channel multiplier, up to 2^24
    localparam int PROD_W  = 33;   // brightness times multiplier, up to 2^32
    localparam int SCL_W   = PROD_W + CH_W; // product times 255

    localparam logic [SV_W-1:0]    UNITY_SV       = 9'd256;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET    = 3'd3;
    localparam logic [MUL_W-1:0]   MUL_ONE        = 25'h100_0000;
    localparam logic [HUE_W:0]     FRAC_ONE       = 17'h1_0000;

    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;

    typedef struct packed {
        logic mul_en;    // load the product register
        logic scale_en;  // load the output register
    } t_pipe_en;

endpackage

/* rtl/core/hsv_to_rgb_converter_unit.sv */
// HSV to RGB converter, top level. Uses hsv2rgb_pkg and hsv2rgb_chan.
// Four-stage pipeline with valid/ready on both sides.
`timescale 1ns / 1ps

// The block takes one HSV pixel per clock while o_ready is high and returns
// one 8-bit RGB pixel per transaction. It is a four-stage pipeline: clamp,
// brightness shift and hue sector (stage 1); the two hue-fraction multiplies
// and the six-sector select (stage 2); brightness times channel multiplier
// (stage 3); the 255/256 scale with truncation into the output register
// (stage 4). Sustained rate is one transaction per cycle while the output
// does not stall; a stall on the output holds each full stage from the output
// back to the first empty one, and o_ready follows i_ready through the stage
// enables, so a bubble anywhere in the pipeline is filled while downstream is
// stalled. Saturation and brightness above 256 are clamped to 256. The
// brightness shift register (reset value 3) is written through i_cfg_we /
// i_cfg_data and should only be changed while no transaction is in flight.

module hsv_to_rgb_converter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsv2rgb_pkg::SHIFT_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [hsv2rgb_pkg::SV_W-1:0]      i_saturation,
    input  logic [hsv2rgb_pkg::SV_W-1:0]      i_brightness,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_blue
);
    import hsv2rgb_pkg::*;

    // ---------------- configuration ----------------
    logic [SHIFT_W-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_data;
        end
    end

    // ---------------- pipeline control ----------------
    // A stage advances when it is empty or the stage after it advances.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;
    t_pipe_en w_en;

    assign w_adv4 = !r_v4 || i_ready;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    assign w_en.mul_en   = w_adv3;
    assign w_en.scale_en = w_adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: clamp, shift, sector ----------------
    logic [SV_W-1:0]    w_s_cl, w_v_cl;
    logic [HUE_W+2:0]   w_h6;
    logic [SEC_W-1:0]   r_s1_sec, n_s1_sec;
    logic [HUE_W-1:0]   r_s1_frac, n_s1_frac;
    logic [SV_W-1:0]    r_s1_sat, n_s1_sat;
    logic [SV_W-1:0]    r_s1_vs, n_s1_vs;

    assign w_s_cl = (i_saturation > UNITY_SV) ? UNITY_SV : i_saturation;
    assign w_v_cl = (i_brightness > UNITY_SV) ? UNITY_SV : i_brightness;

    // hue * 6 as (hue << 2) + (hue << 1); sector sits above the fraction
    assign w_h6 = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};

    assign n_s1_sec  = w_h6[HUE_W+2:HUE_W];
    assign n_s1_frac = w_h6[HUE_W-1:0];
    assign n_s1_sat  = w_s_cl;
    assign n_s1_vs   = w_v_cl >> r_shift;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_sec  <= n_s1_sec;
            r_s1_frac <= n_s1_frac;
            r_s1_sat  <= n_s1_sat;
            r_s1_vs   <= n_s1_vs;
        end
    end

    // ---------------- stage 2: p, q, t multipliers and sector select ----------------
    logic [HUE_W+SV_W-1:0]   w_fs;
    logic [HUE_W:0]          w_frac_c;
    logic [HUE_W+SV_W:0]     w_fcs;
    logic [MUL_W-1:0]        w_mp, w_mq, w_mt;
    logic [MUL_W-1:0]        r_s2_mr, n_s2_mr;
    logic [MUL_W-1:0]        r_s2_mg, n_s2_mg;
    logic [MUL_W-1:0]        r_s2_mb, n_s2_mb;
    logic [SV_W-1:0]         r_s2_vs;

    // f*s and (1-f)*s never exceed 2^24
    assign w_fs     = r_s1_frac * r_s1_sat;
    assign w_frac_c = FRAC_ONE - {1'b0, r_s1_frac};
    assign w_fcs    = w_frac_c * r_s1_sat;

    assign w_mp = {UNITY_SV - r_s1_sat, {HUE_W{1'b0}}};
    assign w_mq = MUL_ONE - w_fs;
    assign w_mt = MUL_ONE - w_fcs[MUL_W-1:0];

    always_comb begin
        case (r_s1_sec)
            SEC_RED_YEL: begin
                n_s2_mr = MUL_ONE; n_s2_mg = w_mt;    n_s2_mb = w_mp;
            end
            SEC_YEL_GRN: begin
                n_s2_mr = w_mq;    n_s2_mg = MUL_ONE; n_s2_mb = w_mp;
            end
            SEC_GRN_CYN: begin
                n_s2_mr = w_mp;    n_s2_mg = MUL_ONE; n_s2_mb = w_mt;
            end
            SEC_CYN_BLU: begin
                n_s2_mr = w_mp;    n_s2_mg = w_mq;    n_s2_mb = MUL_ONE;
            end
            SEC_BLU_MAG: begin
                n_s2_mr = w_mt;    n_s2_mg = w_mp;    n_s2_mb = MUL_ONE;
            end
            default: begin
                // magenta to red; sectors six and seven cannot occur
                n_s2_mr = MUL_ONE; n_s2_mg = w_mp;    n_s2_mb = w_mq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_mr <= n_s2_mr;
            r_s2_mg <= n_s2_mg;
            r_s2_mb <= n_s2_mb;
            r_s2_vs <= r_s1_vs;
        end
    end

    // ---------------- stages 3 and 4: per-channel multiply and scale ----------------
    hsv2rgb_chan u_chan_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vs   (r_s2_vs),
        .i_mul  (r_s2_mr),
        .o_chan (o_red)
    );

    hsv2rgb_chan u_chan_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vs   (r_s2_vs),
        .i_mul  (r_s2_mg),
        .o_chan (o_green)
    );

    hsv2rgb_chan u_chan_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vs   (r_s2_vs),
        .i_mul  (r_s2_mb),
        .o_chan (o_blue)
    );

    assign o_ready = w_adv1;
    assign o_valid = r_v4;

endmodule

/* rtl/core/hsv2rgb_chan.sv */
// One colour channel: brightness times channel multiplier, then the 255/256
// scale with truncation. Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_chan (
    input  logic                           i_clk,
    input  hsv2rgb_pkg::t_pipe_en          i_en,
    input  logic [hsv2rgb_pkg::SV_W-1:0]   i_vs,
    input  logic [hsv2rgb_pkg::MUL_W-1:0]  i_mul,
    output logic [hsv2rgb_pkg::CH_W-1:0]   o_chan
);
    import hsv2rgb_pkg::*;

    logic [SV_W+MUL_W-1:0] w_prod;
    logic [PROD_W-1:0]     r_x;
    logic [PROD_W-1:0]     n_x;
    logic [SCL_W-1:0]      w_scaled;
    logic [CH_W-1:0]       r_chan;
    logic [CH_W-1:0]       n_chan;

    // value never exceeds 2^32, so the top product bit is always clear
    assign w_prod = i_vs * i_mul;
    assign n_x    = w_prod[PROD_W-1:0];

    // x * 255 as (x << 8) - x, then keep bits 39..32
    assign w_scaled = {r_x, {CH_W{1'b0}}} - {{CH_W{1'b0}}, r_x};
    assign n_chan   = w_scaled[PROD_W+CH_W-2 -: CH_W];

    always_ff @(posedge i_clk) begin
        if (i_en.mul_en) begin
            r_x <= n_x;
        end
        if (i_en.scale_en) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

/* rtl/core/hsv2rgb_checker.sv */
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_unit_defines.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv2rgb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [hsv2rgb_pkg::SHIFT_W-1:0]   i_cfg_data,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input logic [hsv2rgb_pkg::SV_W-1:0]      i_saturation,
    input logic [hsv2rgb_pkg::SV_W-1:0]      i_brightness,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [hsv2rgb_pkg::CH_W-1:0]      o_red,
    input logic [hsv2rgb_pkg::CH_W-1:0]      o_green,
    input logic [hsv2rgb_pkg::CH_W-1:0]      o_blue
);
    import hsv2rgb_pkg::*;

    // a stalled result holds
    `HSV2RGB_ASSERT_RUN(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue)), "output changed while stalled")

    // reset empties the pipeline
    `HSV2RGB_ASSERT_ALWAYS(a_rst_empty, (i_rst_n && $past(!i_rst_n)) |-> !o_valid, "result valid after reset")

    // an empty output stage never back-pressures the input
    `HSV2RGB_ASSERT_RUN(a_ready_free, !o_valid |-> o_ready, "input stalled with output empty")

    // with no output stall an accepted transaction comes out of the output stage
    `HSV2RGB_ASSERT_RUN(a_latency, (i_valid && o_ready && i_ready) ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid, "transaction lost in pipeline")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (.*);
